// ----- hdl/smcr_pkg.sv -----
// smcr_pkg: shared types and constants for the switch matrix command router
// no dependencies
package smcr_pkg;

  localparam int LINE_DEPTH = 10;
  localparam int BUF_DEPTH  = LINE_DEPTH - 1;
  localparam int CNT_W      = $clog2(LINE_DEPTH);
  localparam int IDX_W      = $clog2(BUF_DEPTH);

  localparam logic [1:0] PORT_HOST = 2'd0;
  localparam logic [1:0] PORT_VERT = 2'd1;
  localparam logic [1:0] PORT_HORZ = 2'd2;
  localparam logic [1:0] PORT_NONE = 2'd3;

  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] CH_LF = 8'd10;

  // message codes, each an outgoing byte sequence
  typedef enum logic [3:0] {
    MSG_GR, MSG_CE1, MSG_CE2, MSG_RE1, MSG_RE2, MSG_FV, MSG_FH, MSG_LS, MSG_NONE
  } msg_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DECODE, ST_EMIT, ST_FINAL
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic step;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [4:0] total;
  } dp_stat_t;

endpackage

// ----- hdl/smcr_ctrl.sv -----
// smcr_ctrl: sequencer for one input word and its result words
// depends on smcr_pkg
module smcr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_fire,
  input  logic                out_fire,
  input  smcr_pkg::dp_stat_t  stat,
  output smcr_pkg::dp_cmd_t   cmd,
  output logic                busy,
  output logic                out_valid,
  output logic                out_last
);

  smcr_pkg::state_t state, state_next;
  logic [4:0] idx, idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= smcr_pkg::ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    cmd        = '0;
    busy       = 1'b1;
    out_valid  = 1'b0;
    out_last   = 1'b0;
    unique case (state)
      smcr_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (in_fire) begin
          cmd.load   = 1'b1;
          state_next = smcr_pkg::ST_DECODE;
        end
      end
      smcr_pkg::ST_DECODE: begin
        idx_next   = '0;
        state_next = smcr_pkg::ST_EMIT;
      end
      smcr_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        out_last  = (idx == stat.total - 5'd1);
        if (out_fire) begin
          cmd.step = 1'b1;
          idx_next = idx + 5'd1;
          if (out_last) state_next = smcr_pkg::ST_FINAL;
        end
      end
      smcr_pkg::ST_FINAL: begin
        state_next = smcr_pkg::ST_IDLE;
      end
      default: state_next = smcr_pkg::ST_IDLE;
    endcase
  end

  a_total_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == smcr_pkg::ST_EMIT |-> stat.total != 5'd0) else $error("empty result run");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    state == smcr_pkg::ST_EMIT |-> idx < stat.total) else $error("index past run");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    state == smcr_pkg::ST_FINAL |=> state == smcr_pkg::ST_IDLE) else $error("no return");

endmodule

// ----- hdl/smcr_dp.sv -----
// smcr_dp: line buffer, command decode, result byte generation, state registers
// depends on smcr_pkg
module smcr_dp (
  input  logic               clk,
  input  logic               rst,
  input  smcr_pkg::dp_cmd_t  cmd,
  input  logic               in_op,
  input  logic [7:0]         in_rx,
  input  logic               in_lvl,
  output smcr_pkg::dp_stat_t stat,
  output logic [1:0]         port,
  output logic [7:0]         out_byte,
  output logic [3:0]         switch_states,
  output logic               tdm_on,
  output logic               tdm_transmit
);

  logic [7:0] chars [smcr_pkg::BUF_DEPTH];
  logic [smcr_pkg::CNT_W-1:0] char_count;
  logic [3:0] switch_bits;
  logic tdm_active, tdm_sender;

  // captured input word
  logic op_r;
  logic [7:0] rx_r;
  // decoded action
  logic [7:0] c [5];
  smcr_pkg::msg_t msg;
  logic has_cmd;   // line end with buffered chars
  logic [1:0] fwd; // link port for a forwarded command, host otherwise
  logic [4:0] ptr;

  // command length: first nul or count
  logic [smcr_pkg::CNT_W-1:0] len;
  always_comb begin
    len = char_count;
    for (int i = smcr_pkg::BUF_DEPTH - 1; i >= 0; i--)
      if (i < char_count && chars[i] == 8'd0) len = smcr_pkg::CNT_W'(i);
  end

  function automatic logic [7:0] pair(input logic [7:0] hi, input logic [7:0] lo);
    pair = 8'((hi << 3) + (hi << 1) + lo - 8'd16);
  endfunction

  logic [7:0] yv, xv, ym, xm;
  logic is5, w_rf, w_ts, w_tr, w_to;
  logic cmd_ok, is_fv, is_fh;
  assign is5  = (len == smcr_pkg::CNT_W'(5));
  assign w_rf = is5 && chars[0] == "R" && chars[1] == "F" && chars[2] == "F"
                && chars[3] == "F" && chars[4] == "F";
  assign w_ts = len == smcr_pkg::CNT_W'(4) && chars[0] == "T" && chars[1] == "D"
                && chars[2] == "M" && chars[3] == "S";
  assign w_tr = len == smcr_pkg::CNT_W'(4) && chars[0] == "T" && chars[1] == "D"
                && chars[2] == "M" && chars[3] == "R";
  assign w_to = len == smcr_pkg::CNT_W'(4) && chars[0] == "T" && chars[1] == "D"
                && chars[2] == "M" && chars[3] == "O";
  assign yv = pair(chars[1], chars[2]);
  assign xv = pair(chars[3], chars[4]);
  assign ym = yv - 8'd2;
  assign xm = xv - 8'd2;

  // well formed command with both coordinates in range, and where it goes
  assign cmd_ok = is5 && (chars[0] == "C" || chars[0] == "R")
                  && yv >= 8'd1 && yv <= 8'd99 && xv >= 8'd1 && xv <= 8'd99;
  assign is_fv  = cmd_ok && yv > 8'd2;
  assign is_fh  = cmd_ok && yv <= 8'd2 && xv > 8'd2;

  // two digit split of a value below 98, divide by ten via reciprocal multiply
  function automatic logic [15:0] digits(input logic [7:0] v);
    logic [18:0] p;
    logic [7:0] q;
    logic [7:0] t;
    p = 19'(v) * 19'd205;
    q = p[18:11];
    t = v - 8'((q << 3) + (q << 1));
    digits = {q + 8'd48, t + 8'd48};
  endfunction

  logic [15:0] ydig, xdig;
  assign ydig = digits(ym);
  assign xdig = digits(xm);

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count   <= '0;
      switch_bits  <= '0;
      tdm_active   <= 1'b0;
      tdm_sender   <= 1'b0;
      ptr          <= '0;
      has_cmd      <= 1'b0;
      msg          <= smcr_pkg::MSG_NONE;
    end else begin
      if (cmd.load) begin
        op_r <= in_op; rx_r <= in_rx;
        ptr  <= '0;
        has_cmd <= 1'b0;
        msg  <= smcr_pkg::MSG_NONE;
        fwd  <= smcr_pkg::PORT_HOST;
        if (!in_op) begin
          if (in_rx == smcr_pkg::CH_CR || in_rx == smcr_pkg::CH_LF) begin
            if (char_count != '0) begin
              has_cmd <= 1'b1;
              char_count <= '0;
              // command copy, with the lowered coordinate rewritten
              c[0] <= chars[0];
              c[1] <= is_fv ? ydig[15:8] : chars[1];
              c[2] <= is_fv ? ydig[7:0]  : chars[2];
              c[3] <= is_fh ? xdig[15:8] : chars[3];
              c[4] <= is_fh ? xdig[7:0]  : chars[4];
              if (w_rf) begin
                msg <= smcr_pkg::MSG_GR; switch_bits <= '0;
              end else if (w_ts) begin
                tdm_active <= 1'b1; tdm_sender <= 1'b1;
              end else if (w_tr) begin
                tdm_active <= 1'b1; tdm_sender <= 1'b0;
              end else if (w_to) begin
                tdm_active <= 1'b0; tdm_sender <= 1'b0;
                switch_bits <= switch_bits & 4'hC;
              end else if (!is5) msg <= smcr_pkg::MSG_CE1;
              else if (chars[0] != "C" && chars[0] != "R") msg <= smcr_pkg::MSG_CE2;
              else if (yv < 8'd1 || yv > 8'd99) msg <= smcr_pkg::MSG_RE1;
              else if (xv < 8'd1 || xv > 8'd99) msg <= smcr_pkg::MSG_RE2;
              else if (yv > 8'd2) begin
                msg <= smcr_pkg::MSG_FV; fwd <= smcr_pkg::PORT_VERT;
              end else if (xv > 8'd2) begin
                msg <= smcr_pkg::MSG_FH; fwd <= smcr_pkg::PORT_HORZ;
              end else begin
                msg <= smcr_pkg::MSG_LS;
                if (chars[0] == "C")
                  switch_bits[{yv[0] ^ 1'b0 ? 1'b0 : 1'b1, xv[0] ? 1'b0 : 1'b1}]
                    <= 1'b1;
                else
                  switch_bits[{yv[0] ? 1'b0 : 1'b1, xv[0] ? 1'b0 : 1'b1}] <= 1'b0;
              end
            end
          end else if (char_count < smcr_pkg::CNT_W'(smcr_pkg::BUF_DEPTH)) begin
            chars[char_count[smcr_pkg::IDX_W-1:0]] <= in_rx;
            char_count <= char_count + 1'b1;
          end
        end else if (tdm_active && !tdm_sender) begin
          switch_bits <= {switch_bits[3:2], in_lvl, ~in_lvl};
        end
      end
      if (cmd.step) ptr <= ptr + 5'd1;
    end
  end

  // message text table: 3 or 4 chars, none for MSG_NONE
  logic [7:0] mt [4];
  logic [2:0] mlen;
  always_comb begin
    mt = '{8'd0, 8'd0, 8'd0, 8'd0};
    mlen = 3'd3;
    unique case (msg)
      smcr_pkg::MSG_GR:  mt = '{"G", "R", "#", 8'd0};
      smcr_pkg::MSG_CE1: begin mt = '{"C", "E", "!", "1"}; mlen = 3'd4; end
      smcr_pkg::MSG_CE2: begin mt = '{"C", "E", "!", "2"}; mlen = 3'd4; end
      smcr_pkg::MSG_RE1: begin mt = '{"R", "E", "!", "1"}; mlen = 3'd4; end
      smcr_pkg::MSG_RE2: begin mt = '{"R", "E", "!", "2"}; mlen = 3'd4; end
      smcr_pkg::MSG_FV:  mt = '{"F", "V", "#", 8'd0};
      smcr_pkg::MSG_FH:  mt = '{"F", "H", "#", 8'd0};
      smcr_pkg::MSG_LS:  mt = '{"L", "S", "#", 8'd0};
      default: mlen = 3'd0;
    endcase
  end

  // sequence: echo, crlf, -CMD crlf, [msg crlf], then body
  // body for GR: RFFFF cr vert, RFFFF cr horz; fwd: cmd crlf host, cmd cr link;
  // local: cmd crlf host; errors and TDM lines have no body; a clock word or plain byte is one word
  logic [4:0] hdr_end, msg_end;
  logic [4:0] k;
  always_comb begin
    hdr_end = 5'd9;
    msg_end = (msg == smcr_pkg::MSG_NONE) ? hdr_end : hdr_end + 5'(mlen) + 5'd2;
    if (op_r || !has_cmd) stat.total = 5'd1;
    else if (msg == smcr_pkg::MSG_GR) stat.total = msg_end + 5'd12;
    else if (msg == smcr_pkg::MSG_FV || msg == smcr_pkg::MSG_FH)
      stat.total = msg_end + 5'd13;
    else if (msg == smcr_pkg::MSG_LS) stat.total = msg_end + 5'd7;
    else stat.total = msg_end;

    port = smcr_pkg::PORT_HOST;
    out_byte = 8'd0;
    k = '0;
    if (op_r) port = smcr_pkg::PORT_NONE;
    else if (ptr == 5'd0) out_byte = rx_r;
    else if (ptr < hdr_end) begin
      case (ptr)
        5'd1, 5'd7: out_byte = smcr_pkg::CH_CR;
        5'd2, 5'd8: out_byte = smcr_pkg::CH_LF;
        5'd3: out_byte = "-";
        5'd4: out_byte = "C";
        5'd5: out_byte = "M";
        default: out_byte = "D";
      endcase
    end else if (ptr < msg_end) begin
      k = ptr - hdr_end;
      if (k < 5'(mlen)) out_byte = mt[k[1:0]];
      else out_byte = (k == 5'(mlen)) ? smcr_pkg::CH_CR : smcr_pkg::CH_LF;
    end else begin
      k = ptr - msg_end;
      if (msg == smcr_pkg::MSG_GR) begin
        port = (k < 5'd6) ? smcr_pkg::PORT_VERT : smcr_pkg::PORT_HORZ;
        if (k >= 5'd6) k = k - 5'd6;
        case (k)
          5'd0: out_byte = "R";
          5'd5: out_byte = smcr_pkg::CH_CR;
          default: out_byte = "F";
        endcase
      end else if (k < 5'd5) out_byte = c[k[2:0]];
      else if (k == 5'd5) out_byte = smcr_pkg::CH_CR;
      else if (k == 5'd6) out_byte = smcr_pkg::CH_LF;
      else begin
        port = fwd;
        out_byte = (k == 5'd12) ? smcr_pkg::CH_CR : c[3'(k - 5'd7)];
      end
    end
  end

  assign switch_states = switch_bits;
  assign tdm_on        = tdm_active;
  assign tdm_transmit  = tdm_sender;

endmodule

// ----- hdl/switch_matrix_command_router_unit.sv -----
// switch_matrix_command_router_unit: top level of the command router
// depends on smcr_pkg, smcr_ctrl, smcr_dp
//
// channel | dir | tdata (low bit up)                        | tuser | tlast
// s_axis  | in  | rx_byte[7:0], clock_level[8]              | op    | -
// m_axis  | out | out_byte, switch_states, tdm_on, tdm_tx   | port  | last
//
// one input word is loaded in idle, then runs decode, emit (1 to 27 result words) and final
// the output counter in the controller sets the pace, one word per cycle while m_axis is ready
// rst is synchronous: clears line count, switches and tdm mode
// a stall on m_axis holds the current result; s_axis is not ready until done
module switch_matrix_command_router_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // rx_byte[7:0], clock_level[8]
  input  logic        s_axis_tuser,  // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // out_byte[7:0], switch_states[11:8],
                                     // tdm_on[12], tdm_transmit[13]
  output logic [1:0]  m_axis_tuser,  // port
  output logic        m_axis_tlast
);

  smcr_pkg::dp_cmd_t  cmd;
  smcr_pkg::dp_stat_t stat;
  logic busy, in_fire, out_fire;
  logic [7:0] ob;
  logic [3:0] sw;
  logic ton, ttx;

  assign s_axis_tready = !busy;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  smcr_ctrl u_ctrl (
    .clk, .rst, .in_fire, .out_fire, .stat, .cmd, .busy,
    .out_valid(m_axis_tvalid), .out_last(m_axis_tlast)
  );

  smcr_dp u_dp (
    .clk, .rst, .cmd,
    .in_op(s_axis_tuser), .in_rx(s_axis_tdata[7:0]), .in_lvl(s_axis_tdata[8]),
    .stat,
    .port(m_axis_tuser), .out_byte(ob), .switch_states(sw),
    .tdm_on(ton), .tdm_transmit(ttx)
  );

  assign m_axis_tdata = {2'b00, ttx, ton, sw, ob};

endmodule

// ----- dv/smcr_result_checker.sv -----
`timescale 1ns / 100ps
// smcr_result_checker: watches both stream channels of the command router,
// predicts every result word and compares it; depends on smcr_pkg
module smcr_result_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  output int          fail_count,
  output int          pending_words,
  output int          checked_words
);

  typedef struct packed {
    logic [1:0] port;
    logic [7:0] data;
    logic [3:0] sw;
    logic       on;
    logic       tx;
    logic       last;
  } router_word_t;

  router_word_t expected_words[$];
  router_word_t step_words[$];

  logic [7:0] line_buf[smcr_pkg::BUF_DEPTH];
  int         line_cnt;
  logic [3:0] sw_bits;
  logic       tdm_act;
  logic       tdm_tx;

  function automatic void emit(logic [1:0] port, logic [7:0] b);
    router_word_t w;
    w = '0;
    w.port = port;
    w.data = b;
    step_words.push_back(w);
  endfunction

  function automatic void emit_text(logic [1:0] port, string s);
    for (int i = 0; i < s.len(); i++) emit(port, s[i]);
  endfunction

  function automatic void emit_line(string s);
    emit_text(smcr_pkg::PORT_HOST, s);
    emit(smcr_pkg::PORT_HOST, smcr_pkg::CH_CR);
    emit(smcr_pkg::PORT_HOST, smcr_pkg::CH_LF);
  endfunction

  function automatic bit line_is(string w, int len);
    if (w.len() != len) return 0;
    for (int i = 0; i < len; i++)
      if (line_buf[i] != w[i]) return 0;
    return 1;
  endfunction

  function automatic int coord(logic [7:0] hi, logic [7:0] lo);
    return (int'(hi) * 10 + int'(lo) - 528) & 255;
  endfunction

  // decode a finished line of len characters
  function automatic void run_command(int len);
    logic [7:0] c[5];
    int y;
    int x;
    if (line_is("RFFFF", len)) begin
      emit_line("GR#");
      sw_bits = '0;
      emit_text(smcr_pkg::PORT_VERT, "RFFFF\r");
      emit_text(smcr_pkg::PORT_HORZ, "RFFFF\r");
      return;
    end
    if (line_is("TDMS", len)) begin
      tdm_act = 1; tdm_tx = 1; return;
    end
    if (line_is("TDMR", len)) begin
      tdm_act = 1; tdm_tx = 0; return;
    end
    if (line_is("TDMO", len)) begin
      tdm_act = 0; tdm_tx = 0; sw_bits[1:0] = 2'b00; return;
    end
    if (len != 5) begin
      emit_line("CE!1"); return;
    end
    for (int i = 0; i < 5; i++) c[i] = line_buf[i];
    if (c[0] != "C" && c[0] != "R") begin
      emit_line("CE!2"); return;
    end
    y = coord(c[1], c[2]);
    x = coord(c[3], c[4]);
    if (y < 1 || y > 99) begin
      emit_line("RE!1"); return;
    end
    if (x < 1 || x > 99) begin
      emit_line("RE!2"); return;
    end
    if (y > 2) begin
      y -= 2;
      c[1] = 8'(y / 10 + 48);
      c[2] = 8'(y % 10 + 48);
      emit_line("FV#");
      for (int i = 0; i < 5; i++) emit(smcr_pkg::PORT_HOST, c[i]);
      emit(smcr_pkg::PORT_HOST, smcr_pkg::CH_CR); emit(smcr_pkg::PORT_HOST, smcr_pkg::CH_LF);
      for (int i = 0; i < 5; i++) emit(smcr_pkg::PORT_VERT, c[i]);
      emit(smcr_pkg::PORT_VERT, smcr_pkg::CH_CR);
    end else if (x > 2) begin
      x -= 2;
      c[3] = 8'(x / 10 + 48);
      c[4] = 8'(x % 10 + 48);
      emit_line("FH#");
      for (int i = 0; i < 5; i++) emit(smcr_pkg::PORT_HOST, c[i]);
      emit(smcr_pkg::PORT_HOST, smcr_pkg::CH_CR); emit(smcr_pkg::PORT_HOST, smcr_pkg::CH_LF);
      for (int i = 0; i < 5; i++) emit(smcr_pkg::PORT_HORZ, c[i]);
      emit(smcr_pkg::PORT_HORZ, smcr_pkg::CH_CR);
    end else begin
      emit_line("LS#");
      for (int i = 0; i < 5; i++) emit(smcr_pkg::PORT_HOST, c[i]);
      emit(smcr_pkg::PORT_HOST, smcr_pkg::CH_CR); emit(smcr_pkg::PORT_HOST, smcr_pkg::CH_LF);
      if (c[0] == "C") sw_bits[(y - 1) * 2 + (x - 1)] = 1'b1;
      else             sw_bits[(y - 1) * 2 + (x - 1)] = 1'b0;
    end
  endfunction

  function automatic void predict_router(logic op, logic [7:0] rx, logic lvl);
    int len;
    step_words.delete();
    if (!op) begin
      emit(smcr_pkg::PORT_HOST, rx);
      if (rx == smcr_pkg::CH_CR || rx == smcr_pkg::CH_LF) begin
        if (line_cnt > 0) begin
          len = 0;
          while (len < line_cnt && line_buf[len] != 8'd0) len++;
          emit_line("");
          emit_line("-CMD");
          run_command(len);
          line_cnt = 0;
        end
      end else if (line_cnt < smcr_pkg::BUF_DEPTH) begin
        line_buf[line_cnt] = rx;
        line_cnt++;
      end
    end else begin
      if (tdm_act && !tdm_tx) sw_bits[1:0] = lvl ? 2'b10 : 2'b01;
      emit(smcr_pkg::PORT_NONE, 8'd0);
    end
    foreach (step_words[i]) begin
      step_words[i].sw   = sw_bits;
      step_words[i].on   = tdm_act;
      step_words[i].tx   = tdm_tx;
      step_words[i].last = (i == step_words.size() - 1);
      expected_words.push_back(step_words[i]);
    end
  endfunction

  always @(posedge clk) begin
    router_word_t got;
    router_word_t want;
    if (rst) begin
      line_cnt      = 0;
      sw_bits       = '0;
      tdm_act       = 0;
      tdm_tx        = 0;
      fail_count    = 0;
      checked_words = 0;
      expected_words.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        predict_router(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[8]);
      if (m_axis_tvalid && m_axis_tready) begin
        got.port = m_axis_tuser;
        got.data = m_axis_tdata[7:0];
        got.sw   = m_axis_tdata[11:8];
        got.on   = m_axis_tdata[12];
        got.tx   = m_axis_tdata[13];
        got.last = m_axis_tlast;
        checked_words++;
        if (expected_words.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected word port=%0d byte=%02h", $time, got.port, got.data);
        end else begin
          want = expected_words.pop_front();
          if (got != want) begin
            fail_count++;
            $display("%0t: expected port=%0d byte=%02h sw=%h on=%b tx=%b last=%b",
                     $time, want.port, want.data, want.sw, want.on, want.tx, want.last);
            $display("%0t:   actual port=%0d byte=%02h sw=%h on=%b tx=%b last=%b",
                     $time, got.port, got.data, got.sw, got.on, got.tx, got.last);
          end
        end
      end
    end
    pending_words = expected_words.size();
  end

endmodule

// ----- dv/tb_switch_matrix_command_router_unit.sv -----
`timescale 1ns / 100ps
// tb_switch_matrix_command_router_unit: stimulus and verdict for the router
// depends on smcr_pkg, the router rtl and smcr_result_checker
module tb_switch_matrix_command_router_unit;

  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_CLOCK = 1'b1;
  localparam int   STALL_LIMIT = 3000;
  localparam int   ITEM_GOAL   = 460;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  int fail_count;
  int pending_words;
  int checked_words;
  int words_sent;
  int lines_sent;
  int idle_cycles;
  bit no_gaps;       // burst stretch, sender offers back to back
  bit hold_off_req;  // ask the receiver for one long stall

  switch_matrix_command_router_unit u_dut (.*);

  smcr_result_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_word(logic op, logic [7:0] rx, logic lvl);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {7'd0, lvl, rx};
    // ready is stable mid-cycle, so the word goes at the following edge
    forever begin
      @(negedge clk);
      if (s_axis_tready) break;
    end
    @(posedge clk);
    words_sent++;
  endtask

  task automatic send_line(string s, logic [7:0] term);
    for (int i = 0; i < s.len(); i++) send_word(OP_BYTE, s[i], $urandom_range(0, 1));
    send_word(OP_BYTE, term, $urandom_range(0, 1));
    lines_sent++;
  endtask

  function automatic string two_digits(int v);
    string s;
    s = "00";
    s[0] = 8'(v / 10 + 48);
    s[1] = 8'(v % 10 + 48);
    return s;
  endfunction

  // one two-digit coordinate, biased toward the local range, sometimes random noise
  function automatic string rand_coord();
    string s;
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return two_digits($urandom_range(1, 2));
    if (r < 8) return two_digits($urandom_range(0, 99));
    s = "00";
    s[0] = 8'($urandom_range(0, 255));
    s[1] = 8'($urandom_range(32, 126));
    return s;
  endfunction

  // receiver: random stalls, calm stretches, and one long hold-off
  initial begin
    int mode_left;
    bit calm;
    m_axis_tready = 1'b0;
    mode_left = 0;
    calm = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_off_req = 0;
      end
      if (mode_left == 0) begin
        calm = ($urandom_range(0, 3) == 0);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      if (calm) m_axis_tready <= 1'b1;
      else if ($urandom_range(0, 19) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(5, 30)) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else m_axis_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // watchdog: no word moved on either channel for too long
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else if (!rst) idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout after %0d idle cycles, %0d words pending", idle_cycles,
                 pending_words);
        $display("switch_matrix_command_router_unit: mismatch");
        $finish;
      end
    end
  end

  initial begin
    string cmd;
    int r;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_BYTE;
    words_sent    = 0;
    lines_sent    = 0;
    no_gaps       = 0;
    hold_off_req  = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: each command kind, error paths and corner bytes
    send_word(OP_BYTE, smcr_pkg::CH_CR, 0);       // empty line
    send_word(OP_CLOCK, 8'hFF, 1);                // clock change outside tdm
    send_line("C0101", smcr_pkg::CH_CR);          // local close
    send_line("C0202", smcr_pkg::CH_LF);
    send_line("R0101", smcr_pkg::CH_CR);          // local open
    send_line("C0501", smcr_pkg::CH_CR);          // vertical forward
    send_line("R0199", smcr_pkg::CH_LF);          // horizontal forward
    send_line("X0101", smcr_pkg::CH_CR);          // bad type
    send_line("C00", smcr_pkg::CH_CR);            // bad length
    send_line("C0001", smcr_pkg::CH_CR);          // y out of range
    send_line("C0100", smcr_pkg::CH_CR);          // x out of range
    send_line("C0ABCDEFGHIJ", smcr_pkg::CH_CR);   // overflow, extra dropped
    // nul ends the command
    cmd = "TDMR";
    for (int i = 0; i < cmd.len(); i++) send_word(OP_BYTE, cmd[i], 0);
    send_word(OP_BYTE, 8'h00, 0);
    send_word(OP_BYTE, "Q", 0);
    send_word(OP_BYTE, smcr_pkg::CH_CR, 0);
    lines_sent++;
    send_word(OP_CLOCK, 8'h00, 0);
    send_word(OP_CLOCK, 8'h00, 1);
    send_word(OP_CLOCK, 8'h00, 1);                // repeated level still counts
    send_line("TDMS", smcr_pkg::CH_CR);
    send_word(OP_CLOCK, 8'h00, 0);                // ignored while transmitting
    send_line("TDMO", smcr_pkg::CH_LF);
    send_line("RFFFF", smcr_pkg::CH_CR);          // global reset

    // long receiver hold-off while the sender keeps offering
    hold_off_req = 1;
    no_gaps = 1;
    for (int i = 0; i < 6; i++) send_line("C9999", smcr_pkg::CH_CR);
    no_gaps = 0;

    // random: mostly well formed commands, some words, clocks and noise
    while (words_sent < ITEM_GOAL) begin
      if ($urandom_range(0, 9) == 0) no_gaps = ~no_gaps;
      r = $urandom_range(0, 99);
      if (r < 65) begin
        cmd = "C";
        if ($urandom_range(0, 9) == 0) cmd[0] = 8'($urandom_range(0, 255));
        else if ($urandom_range(0, 1)) cmd = "R";
        send_line({cmd, rand_coord(), rand_coord()},
                  $urandom_range(0, 1) ? smcr_pkg::CH_CR : smcr_pkg::CH_LF);
      end else if (r < 77) begin
        case ($urandom_range(0, 4))
          0: cmd = "RFFFF";
          1: cmd = "TDMS";
          2, 3: cmd = "TDMR";
          default: cmd = "TDMO";
        endcase
        send_line(cmd, $urandom_range(0, 1) ? smcr_pkg::CH_CR : smcr_pkg::CH_LF);
      end else if (r < 90) begin
        repeat ($urandom_range(1, 4))
          send_word(OP_CLOCK, 8'($urandom_range(0, 255)), $urandom_range(0, 1));
      end else begin
        repeat ($urandom_range(1, 12))
          send_word(OP_BYTE, 8'($urandom_range(0, 255)), $urandom_range(0, 1));
        if ($urandom_range(0, 1)) send_word(OP_BYTE, smcr_pkg::CH_CR, 0);
      end
    end
    s_axis_tvalid <= 1'b0;

    // let the checker take in the last word before waiting for the drain
    @(posedge clk);
    wait (pending_words == 0);
    repeat (60) @(posedge clk);
    $display("sent %0d input words (%0d lines), checked %0d result words",
             words_sent, lines_sent, checked_words);
    if (fail_count == 0) begin
      $display("switch_matrix_command_router_unit: match");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("switch_matrix_command_router_unit: mismatch");
    end
    $finish;
  end

endmodule
